/* hdl/png_unf_pkg.sv */
// Shared types and constants for the PNG scanline unfilter core.
`default_nettype none

package png_unf_pkg;

   localparam int MAX_ROW_BYTES_DEF = 8192;
   localparam int MAX_BPP_DEF       = 8;

   localparam int BYTE_W  = 8;
   localparam int BPP_W   = 4;
   localparam int WIDTH_W = 14;

   localparam logic [BPP_W-1:0]   BPP_RST   = 4'd4;
   localparam logic [WIDTH_W-1:0] WIDTH_RST = 14'd640;

   // row filter; every type above Paeth is folded into FILT_BAD
   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4,
      FILT_BAD   = 3'd5
   } filt_type;

   typedef enum logic {
      CSR_BPP   = 1'b0,
      CSR_WIDTH = 1'b1
   } csr_idx_type;

   // word held in the working register between control and datapath
   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              is_filter;
      logic              first_row;
      logic              row_end;
      filt_type          filt;
   } unf_item_type;

endpackage

`default_nettype wire

/* hdl/png_unf_line_store.sv */
// Previous-row line store: one write port, one registered read port.
`default_nettype none

module png_unf_line_store
   import png_unf_pkg::*;
#(
   parameter int DEPTH  = MAX_ROW_BYTES_DEF,
   parameter int ADDR_W = $clog2(MAX_ROW_BYTES_DEF)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [BYTE_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/png_unf_ctrl.sv */
// Input side: config registers, column tracking, row filter and working register.
`default_nettype none

module png_unf_ctrl
   import png_unf_pkg::*;
#(
   parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF,
   parameter int MAX_BPP       = MAX_BPP_DEF,
   parameter int ADDR_W        = $clog2(MAX_ROW_BYTES_DEF),
   parameter int IDX_W         = 3
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [BYTE_W-1:0]  req_tdata,
   input  wire logic               req_tuser,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic               csr_index,
   input  wire logic [WIDTH_W-1:0] csr_wdata,
   input  wire logic               s1_advance,
   output logic                    s1_valid,
   output unf_item_type            s1_item,
   output logic      [ADDR_W-1:0]  s1_pos,
   output logic      [IDX_W-1:0]   left_idx,
   output logic                    rd_en,
   output logic      [ADDR_W-1:0]  rd_addr
);

   localparam int LEN_W  = $clog2(MAX_ROW_BYTES + 1);
   localparam int PROD_W = WIDTH_W + BPP_W;

   logic [BPP_W-1:0]   bpp_ff;
   logic [WIDTH_W-1:0] width_ff;
   logic [LEN_W-1:0]   col_ff,   col_in;
   logic               first_ff, first_in;
   filt_type           filt_ff,  filt_in;
   logic               s1_valid_ff, s1_valid_in;
   unf_item_type       s1_item_ff;
   logic [ADDR_W-1:0]  s1_pos_ff;

   logic [BPP_W-1:0]   bpp_eff;
   logic [WIDTH_W-1:0] width_eff;
   logic [PROD_W-1:0]  prod;
   logic [LEN_W-1:0]   row_len;
   logic               accept;
   logic               is_filter;
   logic               row_end;
   filt_type           new_filt;
   unf_item_type       item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff   <= BPP_RST;
         width_ff <= WIDTH_RST;
      end else if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_BPP:   bpp_ff   <= csr_wdata[BPP_W-1:0];
            CSR_WIDTH: width_ff <= csr_wdata;
         endcase
      end
   end

   // clamp the registers into range, then row length saturating at the store depth
   always_comb begin
      if (bpp_ff == '0) begin
         bpp_eff = BPP_W'(1);
      end else if (bpp_ff > BPP_W'(MAX_BPP)) begin
         bpp_eff = BPP_W'(MAX_BPP);
      end else begin
         bpp_eff = bpp_ff;
      end
      width_eff = (width_ff == '0) ? WIDTH_W'(1) : width_ff;
      prod      = PROD_W'(width_eff) * PROD_W'(bpp_eff);
      row_len   = (prod > PROD_W'(MAX_ROW_BYTES)) ? LEN_W'(MAX_ROW_BYTES) : LEN_W'(prod);
   end

   assign left_idx = IDX_W'(bpp_eff - BPP_W'(1));

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !s1_valid_ff || s1_advance;
   assign is_filter  = req_tuser || (col_ff == '0);
   assign row_end    = (col_ff >= row_len);
   assign new_filt   = (req_tdata > BYTE_W'(FILT_PAETH)) ? FILT_BAD : filt_type'(req_tdata[2:0]);
   assign rd_addr    = ADDR_W'(col_ff - LEN_W'(1));
   assign rd_en      = accept && !is_filter;

   always_comb begin
      item.data_byte = req_tdata;
      item.is_filter = is_filter;
      item.first_row = first_ff;
      item.row_end   = row_end;
      item.filt      = filt_ff;
   end

   always_comb begin
      col_in      = col_ff;
      first_in    = first_ff;
      filt_in     = filt_ff;
      s1_valid_in = s1_valid_ff;
      if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
         if (is_filter) begin
            col_in  = LEN_W'(1);
            filt_in = new_filt;
            if (req_tuser) begin
               first_in = 1'b1;
            end
         end else if (row_end) begin
            col_in   = '0;
            first_in = 1'b0;
         end else begin
            col_in = col_ff + LEN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         first_ff    <= 1'b1;
         filt_ff     <= FILT_NONE;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         first_ff    <= first_in;
         filt_ff     <= filt_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= item;
         s1_pos_ff  <= rd_addr;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_item  = s1_item_ff;
   assign s1_pos   = s1_pos_ff;

endmodule

`default_nettype wire

/* hdl/png_unf_recon.sv */
// Byte reconstruction: neighbour histories, predictors and output register.
`default_nettype none

module png_unf_recon
   import png_unf_pkg::*;
#(
   parameter int MAX_BPP = MAX_BPP_DEF,
   parameter int ADDR_W  = $clog2(MAX_ROW_BYTES_DEF),
   parameter int IDX_W   = 3
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              s1_valid,
   input  wire unf_item_type      s1_item,
   input  wire logic [ADDR_W-1:0] s1_pos,
   input  wire logic [IDX_W-1:0]  left_idx,
   input  wire logic [BYTE_W-1:0] above_raw,
   output logic                   s1_advance,
   output logic                   wr_en,
   output logic      [ADDR_W-1:0] wr_addr,
   output logic      [BYTE_W-1:0] wr_data,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic      [BYTE_W-1:0] rsp_tdata,
   output logic                   rsp_tlast,
   output logic                   rsp_tuser
);

   logic [BYTE_W-1:0] left_hist_ff [MAX_BPP];
   logic [BYTE_W-1:0] left_hist_in [MAX_BPP];
   logic [BYTE_W-1:0] ul_hist_ff   [MAX_BPP];
   logic [BYTE_W-1:0] ul_hist_in   [MAX_BPP];
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff;
   logic              out_last_ff;
   logic              out_bad_ff;

   logic [BYTE_W-1:0] left, above, upleft, pred, res;
   logic [BYTE_W:0]   avg_sum;
   logic              bad;
   logic              load_out;

   function automatic logic [BYTE_W-1:0] paeth_pick(input logic [BYTE_W-1:0] a,
                                                    input logic [BYTE_W-1:0] b,
                                                    input logic [BYTE_W-1:0] c);
      logic signed [BYTE_W+1:0] sa, sb, sc;
      logic        [BYTE_W+1:0] da, db, dc;
      sa = $signed({2'b00, b}) - $signed({2'b00, c});
      sb = $signed({2'b00, a}) - $signed({2'b00, c});
      sc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
      da = (sa < 0) ? -sa : sa;
      db = (sb < 0) ? -sb : sb;
      dc = (sc < 0) ? -sc : sc;
      if (da <= db && da <= dc) begin
         return a;
      end else if (db <= dc) begin
         return b;
      end else begin
         return c;
      end
   endfunction

   assign left    = left_hist_ff[left_idx];
   assign upleft  = ul_hist_ff[left_idx];
   assign above   = s1_item.first_row ? '0 : above_raw;
   assign avg_sum = {1'b0, left} + {1'b0, above};

   always_comb begin
      bad  = 1'b0;
      pred = '0;
      unique case (s1_item.filt)
         FILT_NONE:  pred = '0;
         FILT_SUB:   pred = left;
         FILT_UP:    pred = above;
         FILT_AVG:   pred = avg_sum[BYTE_W:1];
         FILT_PAETH: pred = paeth_pick(left, above, upleft);
         default:    bad  = 1'b1;
      endcase
      res = bad ? '0 : s1_item.data_byte + pred;
   end

   // filter-type words pass through without touching the output register
   assign s1_advance = s1_valid && (s1_item.is_filter || !out_valid_ff || rsp_tready);
   assign load_out   = s1_advance && !s1_item.is_filter;

   assign wr_en   = load_out;
   assign wr_addr = s1_pos;
   assign wr_data = res;

   always_comb begin
      left_hist_in = left_hist_ff;
      ul_hist_in   = ul_hist_ff;
      if (s1_advance) begin
         if (s1_item.is_filter) begin
            for (int i = 0; i < MAX_BPP; i++) begin
               left_hist_in[i] = '0;
               ul_hist_in[i]   = '0;
            end
         end else begin
            for (int i = MAX_BPP - 1; i > 0; i--) begin
               left_hist_in[i] = left_hist_ff[i-1];
               ul_hist_in[i]   = ul_hist_ff[i-1];
            end
            left_hist_in[0] = res;
            ul_hist_in[0]   = above;
         end
      end
   end

   always_comb begin
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_BPP; i++) begin
            left_hist_ff[i] <= '0;
            ul_hist_ff[i]   <= '0;
         end
         out_valid_ff <= 1'b0;
      end else begin
         left_hist_ff <= left_hist_in;
         ul_hist_ff   <= ul_hist_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_byte_ff <= res;
         out_last_ff <= s1_item.row_end;
         out_bad_ff  <= bad;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_bad_ff;

endmodule

`default_nettype wire

/* hdl/png_scanline_unfilter_core.sv */
// Top level of the PNG scanline unfilter (None/Sub/Up/Average/Paeth) core.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+------------------------------------------
//  req     | in  | req_tvalid/req_tready | tdata: in_byte; tuser: start_of_image
//  rsp     | out | rsp_tvalid/rsp_tready | tdata: out_byte; tlast: row_end;
//          |     |                       | tuser: bad_filter
//  csr     | in  | csr_valid/csr_ready   | csr_index (0 bpp, 1 width), csr_wdata
//
// One word per cycle sustained while the output is not stalled. At accept a data
// word enters the working register and issues the line-store read; as it advances,
// the rebuilt byte is written back and loads the output register. Filter-type words
// give no output word. Synchronous reset clears control and histories; the line
// store is not cleared (rows after the first only read what the previous row wrote).
// rsp stalls hold the output register; req keeps flowing into the working
// register until it is full, and filter words drain past a stalled output.
`default_nettype none

module png_scanline_unfilter_core
   import png_unf_pkg::*;
#(
   parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF,
   parameter int MAX_BPP       = MAX_BPP_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [BYTE_W-1:0]  req_tdata,   // [7:0] in_byte
   input  wire logic               req_tuser,   // [0] start_of_image
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic      [BYTE_W-1:0]  rsp_tdata,   // [7:0] out_byte
   output logic                    rsp_tlast,   // row_end
   output logic                    rsp_tuser,   // [0] bad_filter
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic               csr_index,
   input  wire logic [WIDTH_W-1:0] csr_wdata
);

   localparam int ADDR_W = $clog2(MAX_ROW_BYTES);
   localparam int IDX_W  = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;

   logic              s1_valid;
   logic              s1_advance;
   unf_item_type      s1_item;
   logic [ADDR_W-1:0] s1_pos;
   logic [IDX_W-1:0]  left_idx;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [BYTE_W-1:0] rd_data;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [BYTE_W-1:0] wr_data;

   // column counter, row filter and first-row flag live on the accept side
   png_unf_ctrl #(
      .MAX_ROW_BYTES (MAX_ROW_BYTES),
      .MAX_BPP       (MAX_BPP),
      .ADDR_W        (ADDR_W),
      .IDX_W         (IDX_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .s1_advance (s1_advance),
      .s1_valid   (s1_valid),
      .s1_item    (s1_item),
      .s1_pos     (s1_pos),
      .left_idx   (left_idx),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr)
   );

   // above byte is read at accept and lands alongside the working register
   png_unf_line_store #(
      .DEPTH  (MAX_ROW_BYTES),
      .ADDR_W (ADDR_W)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // left/upper-left come from the byte histories, so Sub at bpp 1 chains
   // straight from the previous word's result
   png_unf_recon #(
      .MAX_BPP (MAX_BPP),
      .ADDR_W  (ADDR_W),
      .IDX_W   (IDX_W)
   ) u_recon (
      .clock      (clock),
      .reset      (reset),
      .s1_valid   (s1_valid),
      .s1_item    (s1_item),
      .s1_pos     (s1_pos),
      .left_idx   (left_idx),
      .above_raw  (rd_data),
      .s1_advance (s1_advance),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

/* hdl/png_unf_checker.sv */
// Port-level checks for the unfilter core, bound to the top level.
`default_nettype none

module png_unf_checker
   import png_unf_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_tvalid,
   input wire logic              req_tready,
   input wire logic              rsp_tvalid,
   input wire logic              rsp_tready,
   input wire logic [BYTE_W-1:0] rsp_tdata,
   input wire logic              rsp_tlast,
   input wire logic              rsp_tuser
);

   // nothing pending comes out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp word valid straight after reset");

   // a stalled output word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled rsp word changed");

   // unknown filter type always yields a zero byte
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("bad filter word carries non-zero byte");

   // from an empty output, a word appears once its input has passed through the working register to the output register
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("rsp word without matching req word");

endmodule

bind png_scanline_unfilter_core png_unf_checker u_png_unf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

/* tb/tb.sv */
// Self-checking bench for the PNG scanline unfilter core: directed rows, then random images.
`default_nettype none

module tb;
   import png_unf_pkg::*;

   localparam int STALL_LIMIT = 5000;  // cycles with no word moving on any channel
   localparam int HOLD_CYCLES = 300;   // long output back-pressure
   localparam int SETTLE      = 4;     // covers the working and output registers and a trailing filter word
   localparam int ADDR_W      = $clog2(MAX_ROW_BYTES_DEF);

   typedef struct packed {
      logic       soi;
      logic [7:0] b;
   } stream_word_type;

   typedef struct packed {
      logic [7:0] px;
      logic       eol;
      logic       bad;
   } rebuilt_type;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [BYTE_W-1:0]  req_tdata  = '0;
   logic               req_tuser  = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [BYTE_W-1:0]  rsp_tdata;
   logic               rsp_tlast;
   logic               rsp_tuser;
   logic               csr_valid  = 1'b0;
   logic               csr_ready;
   logic               csr_index  = 1'b0;
   logic [WIDTH_W-1:0] csr_wdata  = '0;

   png_scanline_unfilter_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   stream_word_type stream_q[$];    // words waiting to be offered on req
   rebuilt_type     rebuilt_q[$];   // reconstructed bytes still owed on rsp

   int   src_idle     = 22;      // percent of cycles the sender holds back
   int   snk_idle     = 52;      // percent of cycles the receiver holds back
   logic rsp_hold     = 1'b0;
   logic req_fire     = 1'b0;    // handshakes seen at the last rising edge
   logic csr_fire     = 1'b0;
   int   mismatch_cnt = 0;
   int   quiet        = 0;

   // shadow of the core: line store, row position, histories, registers
   logic [7:0]         line_mem [MAX_ROW_BYTES_DEF];
   int                 col_pos;
   logic               top_row;
   filt_type           row_filt;
   logic [63:0]        left_hist;
   logic [63:0]        ul_hist;
   logic [BPP_W-1:0]   cfg_bpp;
   logic [WIDTH_W-1:0] cfg_width;

   // registers as the stimulus last wrote them, for sizing rows
   logic [BPP_W-1:0]   plan_bpp   = BPP_RST;
   logic [WIDTH_W-1:0] plan_width = WIDTH_RST;

   function automatic int eff_bpp(input logic [BPP_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_BPP_DEF) return MAX_BPP_DEF;
      return int'(v);
   endfunction

   function automatic int row_bytes(input logic [BPP_W-1:0] v, input logic [WIDTH_W-1:0] w);
      int n;
      n = (w == 0 ? 1 : int'(w)) * eff_bpp(v);
      return (n > MAX_ROW_BYTES_DEF) ? MAX_ROW_BYTES_DEF : n;
   endfunction

   function automatic void new_row();
      col_pos   = 0;
      left_hist = '0;
      ul_hist   = '0;
   endfunction

   // rebuild one stream byte; data bytes queue the expected output word
   function automatic void unfilter_word(input logic [7:0] b, input logic soi);
      int          len, pos, sh, ia, ib, ic, p, da, db, dc;
      logic [7:0]  lft, abv, ul, px;
      logic        bad;
      rebuilt_type r;
      if (soi) begin
         top_row = 1'b1;
         new_row();
      end
      if (col_pos == 0) begin
         row_filt = (b > 8'(FILT_PAETH)) ? FILT_BAD : filt_type'(b[2:0]);
         col_pos  = 1;
         return;
      end
      len = row_bytes(cfg_bpp, cfg_width);
      pos = (col_pos - 1 >= MAX_ROW_BYTES_DEF) ? MAX_ROW_BYTES_DEF - 1 : col_pos - 1;
      sh  = 8 * (eff_bpp(cfg_bpp) - 1);
      lft = left_hist[6'(sh) +: 8];
      ul  = ul_hist[6'(sh) +: 8];
      abv = top_row ? 8'h00 : line_mem[ADDR_W'(pos)];
      ia  = int'(lft);
      ib  = int'(abv);
      ic  = int'(ul);
      bad = 1'b0;
      case (row_filt)
         FILT_NONE:  px = b;
         FILT_SUB:   px = b + lft;
         FILT_UP:    px = b + abv;
         FILT_AVG: begin
            p  = (ia + ib) / 2;
            px = b + p[7:0];
         end
         FILT_PAETH: begin
            p  = ia + ib - ic;
            da = (p > ia) ? p - ia : ia - p;
            db = (p > ib) ? p - ib : ib - p;
            dc = (p > ic) ? p - ic : ic - p;
            if (da <= db && da <= dc) px = b + lft;
            else if (db <= dc) px = b + abv;
            else px = b + ul;
         end
         default: begin
            px  = 8'h00;
            bad = 1'b1;
         end
      endcase
      line_mem[ADDR_W'(pos)] = px;
      left_hist     = {left_hist[55:0], px};
      ul_hist       = {ul_hist[55:0], abv};
      r.px  = px;
      r.bad = bad;
      r.eol = (col_pos >= len);
      rebuilt_q.push_back(r);
      if (r.eol) begin
         top_row = 1'b0;
         new_row();
      end else begin
         col_pos++;
      end
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_cnt++;
      $display("mismatch at %0t: %s got 0x%0h, want 0x%0h", $time, what, got, want);
   endtask

   // sender: next word offered on the falling edge once the last one went
   always @(negedge clock) begin : sender
      stream_word_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (stream_q.size() != 0 && $urandom_range(99) >= src_idle) begin
            w = stream_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= w.b;
            req_tuser  <= w.soi;
         end else begin
            req_tvalid <= 1'b0;
            req_tdata  <= 8'($urandom_range(255));
         end
      end
   end

   always @(negedge clock) begin
      if (reset || rsp_hold) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= snk_idle);
   end

   // monitor: checks output words, tracks register writes, feeds the shadow
   always @(posedge clock) begin : monitor
      rebuilt_type want;
      req_fire <= req_tvalid && req_tready;
      csr_fire <= csr_valid && csr_ready;
      if (reset) begin
         new_row();
         top_row   = 1'b1;
         row_filt  = FILT_NONE;
         cfg_bpp   = BPP_RST;
         cfg_width = WIDTH_RST;
         rebuilt_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (rebuilt_q.size() == 0) begin
               report_mismatch("unexpected output word", int'(rsp_tdata), 0);
            end else begin
               want = rebuilt_q.pop_front();
               if (rsp_tdata !== want.px)
                  report_mismatch("out_byte", int'(rsp_tdata), int'(want.px));
               if (rsp_tlast !== want.eol)
                  report_mismatch("row_end", int'(rsp_tlast), int'(want.eol));
               if (rsp_tuser !== want.bad)
                  report_mismatch("bad_filter", int'(rsp_tuser), int'(want.bad));
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_BPP) cfg_bpp = csr_wdata[BPP_W-1:0];
            else cfg_width = csr_wdata;
         end
         if (req_tvalid && req_tready) unfilter_word(req_tdata, req_tuser);
      end
   end

   // watchdog: too long with nothing moving means the core has hung
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet == STALL_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   function automatic void push_word(input logic [7:0] b, input logic soi);
      stream_word_type w;
      w.b   = b;
      w.soi = soi;
      stream_q.push_back(w);
   endfunction

   task automatic write_csr(input csr_idx_type idx, input logic [WIDTH_W-1:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(negedge clock); while (!csr_fire);
      csr_valid <= 1'b0;
      if (idx == CSR_BPP) plan_bpp = v[BPP_W-1:0];
      else plan_width = v;
      @(posedge clock);
   endtask

   // all words sent and all bytes back, then a settle wait for trailing filter words
   task automatic wait_drained();
      do @(posedge clock); while (stream_q.size() != 0 || req_tvalid || rebuilt_q.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // images at the planned row length, n words in all; brk_odds gives a 1-in-brk_odds
   // chance per data byte of cutting the row short with a new start of image
   task automatic queue_images(input int n, input int brk_odds);
      int         len, k, cnt, r;
      logic       soi;
      logic [7:0] b;
      len = row_bytes(plan_bpp, plan_width);
      cnt = 0;
      soi = 1'b1;
      while (cnt < n) begin
         r = $urandom_range(99);
         if (r < 88) b = 8'($urandom_range(4));
         else b = 8'($urandom_range(255, 5));
         push_word(b, soi);
         cnt++;
         soi = ($urandom_range(19) == 0);
         for (k = 0; k < len && cnt < n; k++) begin
            if (brk_odds != 0 && $urandom_range(brk_odds - 1) == 0) begin
               soi = 1'b1;
               break;
            end
            r = $urandom_range(9);
            if (r == 0) b = 8'h00;
            else if (r == 1) b = 8'hFF;
            else b = 8'($urandom_range(255));
            push_word(b, 1'b0);
            cnt++;
         end
      end
   endtask

   // new geometry, then fresh images so no row reads an unwritten line store byte
   task automatic run_phase(input int bpp, input int width, input int n, input int brk_odds);
      logic [WIDTH_W-1:0] v;
      v = WIDTH_W'($urandom);
      v[BPP_W-1:0] = BPP_W'(bpp);   // junk in the unused upper bits
      write_csr(CSR_BPP, v);
      write_csr(CSR_WIDTH, WIDTH_W'(width));
      queue_images(n, brk_odds);
      wait_drained();
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: one pixel byte, three pixels; first row straight after reset
      write_csr(CSR_BPP, WIDTH_W'(1));
      write_csr(CSR_WIDTH, WIDTH_W'(3));
      push_word(8'h00, 1'b0); push_word(8'h00, 1'b0); push_word(8'hFF, 1'b0);
      push_word(8'h80, 1'b0);
      push_word(8'h01, 1'b0); push_word(8'hFF, 1'b0); push_word(8'h01, 1'b0);
      push_word(8'h7F, 1'b0);
      push_word(8'h02, 1'b0); push_word(8'h10, 1'b0); push_word(8'hF0, 1'b0);
      push_word(8'hFF, 1'b0);
      push_word(8'h03, 1'b0); push_word(8'h03, 1'b0); push_word(8'hFF, 1'b0);
      push_word(8'h80, 1'b0);
      push_word(8'h04, 1'b0); push_word(8'h01, 1'b0); push_word(8'h02, 1'b0);
      push_word(8'hFE, 1'b0);
      // lowest unknown filter type: zeros flagged bad
      push_word(8'h05, 1'b0); push_word(8'h12, 1'b0); push_word(8'h34, 1'b0);
      push_word(8'h56, 1'b0);
      // start of image mid-row restarts the first row with cleared history
      push_word(8'h04, 1'b1); push_word(8'h05, 1'b0);
      push_word(8'hFF, 1'b1); push_word(8'hC8, 1'b0); push_word(8'h64, 1'b0);
      push_word(8'hFF, 1'b0);
      wait_drained();

      // width cut mid-row: position already past the new length, next byte ends it
      push_word(8'h02, 1'b0); push_word(8'hAA, 1'b0); push_word(8'h55, 1'b0);
      wait_drained();
      write_csr(CSR_WIDTH, WIDTH_W'(2));
      push_word(8'h33, 1'b0);
      push_word(8'h04, 1'b0); push_word(8'hF0, 1'b0); push_word(8'h0F, 1'b0);
      wait_drained();

      // random images; bpp 0 and width 0 read as 1, bpp 15 as 8
      run_phase(3, 5, 70, 150);
      run_phase(0, 9, 70, 150);
      run_phase(8, 2, 70, 150);

      src_idle = 52;
      snk_idle = 22;
      // receiver stalls for a long stretch while the sender keeps offering
      fork
         begin
            rsp_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold = 1'b0;
         end
      join_none
      run_phase(15, 1, 120, 150);
      run_phase(5, 0, 60, 150);
      run_phase(1, 1, 40, 150);

      src_idle = 0;
      snk_idle = 0;
      run_phase(2, int'($urandom_range(12, 1)), 70, 150);
      run_phase(7, int'($urandom_range(6, 1)), 70, 150);
      run_phase(int'($urandom_range(8, 1)), int'($urandom_range(40, 13)), 70, 150);
      // widest geometry; the image stops partway into its first row
      run_phase(15, 16383, 40, 0);

      if (mismatch_cnt == 0) $display("tb passed");
      else $display("tb failed");
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
hdl/png_unf_pkg.sv
hdl/png_unf_line_store.sv
hdl/png_unf_ctrl.sv
hdl/png_unf_recon.sv
hdl/png_scanline_unfilter_core.sv
hdl/png_unf_checker.sv
tb/tb.sv
